// ===== src/smu_pkg.sv =====
// ----------------------------------------------------------------------------
// smu_pkg: shared types and constants
// Field widths, register indexes, reset values, scheduler state and the
// structs exchanged between the SGD update blocks.
// ----------------------------------------------------------------------------
package smu_pkg;

   localparam int WORD_W      = 32;
   localparam int RATE_W      = 31;
   localparam int BATCH_W     = 16;
   localparam int MS_W        = 16;
   localparam int MS_ALL_W    = 64;
   localparam int PERIOD_W    = 32;
   localparam int POLICY_W    = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   // element datapath widths
   localparam int PROD_W   = 64;   // 32x32 signed products
   localparam int TERM_W   = 42;   // clamped decay term, +/-2^40
   localparam int TB_W     = 59;   // decay term times batch
   localparam int DIFF_W   = 60;   // gradient minus decay term
   localparam int SAT_IN_W = 66;   // common width into the word saturator

   localparam logic signed [PROD_W-1:0] TERM_LIMIT = 64'sh0000_0100_0000_0000;

   localparam logic [RATE_W-1:0]  RATE_RESET  = 31'd16777;
   localparam logic [RATE_W-1:0]  GAMMA_RESET = 31'd16777216;
   localparam logic [RATE_W-1:0]  RATE_MAX    = 31'h7FFF_FFFF;
   localparam logic [BATCH_W-1:0] BATCH_ONE   = 16'd1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_INITIAL_RATE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECAY        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOMENTUM     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAMMA        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BATCH_SIZE   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_POLICY       = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_PERIOD  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_MILESTONES   = 3'd7;

   // schedule policies
   localparam logic [POLICY_W-1:0] POL_FIXED = 2'd0;
   localparam logic [POLICY_W-1:0] POL_STEP  = 2'd1;
   localparam logic [POLICY_W-1:0] POL_MULTI = 2'd2;

   typedef enum logic [2:0] {
      SCH_IDLE,
      SCH_MOD_WAIT,
      SCH_MS_CHECK,
      SCH_MUL,
      SCH_SAT,
      SCH_DIV_START,
      SCH_DIV_WAIT,
      SCH_INJECT
   } sched_state_type;

   typedef struct packed {
      logic [POLICY_W-1:0] policy;
      logic [PERIOD_W-1:0] period;
      logic [RATE_W-1:0]   gamma;
      logic [MS_ALL_W-1:0] milestones;
      logic [BATCH_W-1:0]  batch;      // zero already mapped to one
   } sched_cfg_type;

   typedef struct packed {
      logic              busy;
      logic              inject;
      logic [RATE_W-1:0] rate;
      logic [RATE_W-1:0] rate_batch;
      logic              changed;
   } sched_status_type;

   typedef struct packed {
      logic                     tick;
      logic                     changed;
      logic                     is_weights;
      logic [RATE_W-1:0]        rate;
      logic [RATE_W-1:0]        rate_batch;
      logic signed [WORD_W-1:0] weight;
      logic signed [WORD_W-1:0] gradient;
   } item_type;

   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SAT_IN_W-1:0] v);
      logic signed [SAT_IN_W-1:0] hi;
      logic signed [SAT_IN_W-1:0] lo;
      hi = 66'sd2147483647;
      lo = -66'sd2147483648;
      if (v > hi) begin
         return hi[WORD_W-1:0];
      end else if (v < lo) begin
         return lo[WORD_W-1:0];
      end
      return v[WORD_W-1:0];
   endfunction

endpackage

// ===== src/sgd_momentum_update_step_lr_unit.sv =====
// ----------------------------------------------------------------------------
// sgd_momentum_update_step_lr_unit: SGD step with momentum, decay and LR schedule
// Top level: register file, input steering, scheduler and element pipeline.
// ----------------------------------------------------------------------------
// Element beats (opcode 0) stream through a five-stage pipeline at one beat
// per clock unless rsp_stall or a busy scheduler holds them; the output
// register lets the next beat enter while a result waits under rsp_stall.
// Each element uses the rate and rate/batch current when it enters. A tick
// beat (opcode 1) holds req_stall high while the scheduler works: a tick at
// iteration zero or under the fixed policy goes straight to injection, a
// periodic-step tick runs the serial divider for the modulo, each scale by
// gamma passes a multiply state and a saturate state, and any tick that may
// have moved the rate ends with a rate/batch refresh on the same divider before
// its result is pushed into the pipeline behind earlier elements. Writing
// initial_rate or batch_size also starts that refresh, so req_stall stays high until it is done.
// ----------------------------------------------------------------------------
module sgd_momentum_update_step_lr_unit #(
   parameter int MILESTONE_SLOTS = 4,
   parameter int FRACTION_BITS   = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_opcode,
   input  logic [smu_pkg::WORD_W-1:0]            req_iteration,
   input  logic signed [smu_pkg::WORD_W-1:0]     req_weight_in,
   input  logic signed [smu_pkg::WORD_W-1:0]     req_gradient_in,
   input  logic                                  req_is_weights,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [smu_pkg::WORD_W-1:0]     rsp_weight_out,
   output logic signed [smu_pkg::WORD_W-1:0]     rsp_gradient_out,
   output logic [smu_pkg::RATE_W-1:0]            rsp_rate_out,
   output logic                                  rsp_rate_changed,
   // register write port
   input  logic                                  csr_write,
   input  logic [smu_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [smu_pkg::CSR_DATA_W-1:0]        csr_data
);
   import smu_pkg::*;

   // configuration registers
   logic [RATE_W-1:0]   decay_ff, decay_in;
   logic [RATE_W-1:0]   momentum_ff, momentum_in;
   logic [RATE_W-1:0]   gamma_ff, gamma_in;
   logic [BATCH_W-1:0]  batch_ff, batch_in;
   logic [POLICY_W-1:0] policy_ff, policy_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [MS_ALL_W-1:0] milestones_ff, milestones_in;

   logic [BATCH_W-1:0]  batch_eff;
   sched_cfg_type       sched_cfg;
   sched_status_type    status;
   item_type            dp_item;
   logic                dp_valid, dp_ready;
   logic                tick_accept, rate_load, rediv;

   always_comb begin
      decay_in      = decay_ff;
      momentum_in   = momentum_ff;
      gamma_in      = gamma_ff;
      batch_in      = batch_ff;
      policy_in     = policy_ff;
      period_in     = period_ff;
      milestones_in = milestones_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_DECAY:       decay_in      = csr_data[RATE_W-1:0];
            CSR_MOMENTUM:    momentum_in   = csr_data[RATE_W-1:0];
            CSR_GAMMA:       gamma_in      = csr_data[RATE_W-1:0];
            CSR_BATCH_SIZE:  batch_in      = csr_data[BATCH_W-1:0];
            CSR_POLICY:      policy_in     = csr_data[POLICY_W-1:0];
            CSR_STEP_PERIOD: period_in     = csr_data[PERIOD_W-1:0];
            CSR_MILESTONES:  milestones_in = csr_data[MS_ALL_W-1:0];
            default: begin
               // initial_rate lives in the scheduler as the rate itself
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff      <= '0;
         momentum_ff   <= '0;
         gamma_ff      <= GAMMA_RESET;
         batch_ff      <= BATCH_ONE;
         policy_ff     <= POL_FIXED;
         period_ff     <= PERIOD_W'(1);
         milestones_ff <= '0;
      end else begin
         decay_ff      <= decay_in;
         momentum_ff   <= momentum_in;
         gamma_ff      <= gamma_in;
         batch_ff      <= batch_in;
         policy_ff     <= policy_in;
         period_ff     <= period_in;
         milestones_ff <= milestones_in;
      end
   end

   // zero batch behaves as one
   assign batch_eff = (batch_ff == '0) ? BATCH_ONE : batch_ff;

   assign sched_cfg.policy     = policy_ff;
   assign sched_cfg.period     = period_ff;
   assign sched_cfg.gamma      = gamma_ff;
   assign sched_cfg.milestones = milestones_ff;
   assign sched_cfg.batch      = batch_eff;

   assign rate_load = csr_write && (csr_index == CSR_INITIAL_RATE);
   assign rediv     = csr_write && (csr_index == CSR_INITIAL_RATE ||
                                    csr_index == CSR_BATCH_SIZE);

   // input side: scheduler busy or a full pipeline head holds the beat
   assign req_stall   = status.busy || !dp_ready;
   assign tick_accept = req_valid && !req_stall && req_opcode;

   smu_sched #(
      .MILESTONE_SLOTS (MILESTONE_SLOTS),
      .FRACTION_BITS   (FRACTION_BITS)
   ) u_sched (
      .clock           (clock),
      .reset           (reset),
      .tick_accept     (tick_accept),
      .tick_iteration  (req_iteration),
      .cfg             (sched_cfg),
      .rate_load       (rate_load),
      .rate_load_value (csr_data[RATE_W-1:0]),
      .rediv           (rediv),
      .dp_ready        (dp_ready),
      .status          (status)
   );

   // pipeline head: finished tick from the scheduler, else an element beat
   always_comb begin
      dp_valid           = status.inject || (req_valid && !status.busy && !req_opcode);
      dp_item.tick       = status.inject;
      dp_item.changed    = status.inject && status.changed;
      dp_item.is_weights = !status.inject && req_is_weights;
      dp_item.rate       = status.rate;
      dp_item.rate_batch = status.rate_batch;
      dp_item.weight     = req_weight_in;
      dp_item.gradient   = req_gradient_in;
   end

   smu_datapath #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (dp_valid),
      .in_item          (dp_item),
      .in_ready         (dp_ready),
      .decay            (decay_ff),
      .momentum         (momentum_ff),
      .batch            (batch_eff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_weight_out   (rsp_weight_out),
      .rsp_gradient_out (rsp_gradient_out),
      .rsp_rate_out     (rsp_rate_out),
      .rsp_rate_changed (rsp_rate_changed)
   );

   // a taken tick must close the input until its result is queued
   a_tick_holds: assert property (@(posedge clock) disable iff (reset)
      tick_accept |=> req_stall)
      else $error("input open straight after a tick beat");

endmodule

// ===== src/smu_divider.sv =====
// ----------------------------------------------------------------------------
// smu_divider: shared iterative unsigned divider
// Restoring division, one quotient bit per cycle; a start restarts it.
// ----------------------------------------------------------------------------
module smu_divider #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             busy,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);
   localparam int CNT_W = $clog2(WIDTH + 1);

   logic             active_ff, active_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] quo_ff, rem_ff, div_ff;
   logic [WIDTH:0]   shifted, diff;

   always_comb begin
      shifted   = {rem_ff, quo_ff[WIDTH-1]};
      diff      = shifted - {1'b0, div_ff};
      active_in = active_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = CNT_W'(WIDTH);
      end else if (active_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (active_ff) begin
         quo_ff <= {quo_ff[WIDTH-2:0], ~diff[WIDTH]};
         rem_ff <= diff[WIDTH] ? shifted[WIDTH-1:0] : diff[WIDTH-1:0];
      end
   end

   assign busy      = active_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== src/smu_sched.sv =====
// ----------------------------------------------------------------------------
// smu_sched: learning-rate state and schedule sequencer
// Holds the current rate and rate/batch, runs ticks and refreshes rate/batch.
// ----------------------------------------------------------------------------
module smu_sched #(
   parameter int MILESTONE_SLOTS = 4,
   parameter int FRACTION_BITS   = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          tick_accept,
   input  logic [smu_pkg::WORD_W-1:0]    tick_iteration,
   input  smu_pkg::sched_cfg_type        cfg,
   input  logic                          rate_load,
   input  logic [smu_pkg::RATE_W-1:0]    rate_load_value,
   input  logic                          rediv,
   input  logic                          dp_ready,
   output smu_pkg::sched_status_type     status
);
   import smu_pkg::*;

   localparam int SLOT_W = (MILESTONE_SLOTS > 1) ? $clog2(MILESTONE_SLOTS) : 1;
   localparam int SPROD_W = 2 * RATE_W;

   sched_state_type     state_ff, state_in;
   logic [RATE_W-1:0]   rate_ff, rate_in;
   logic [RATE_W-1:0]   rb_ff, rb_in;
   logic [RATE_W-1:0]   before_ff, before_in;
   logic [WORD_W-1:0]   it_ff, it_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic                tick_ff, tick_in;
   logic [SPROD_W-1:0]  prod_ff, prod_in;
   logic [SPROD_W-1:0]  scaled;
   logic [MS_W-1:0]     ms_value;
   logic                ms_hit, last_slot, inject;

   logic                div_start, div_busy, div_done;
   logic [WORD_W-1:0]   div_dividend, div_divisor, div_quotient, div_remainder;

   smu_divider #(
      .WIDTH (WORD_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   always_comb begin
      state_in     = state_ff;
      rate_in      = rate_ff;
      rb_in        = rb_ff;
      before_in    = before_ff;
      it_in        = it_ff;
      slot_in      = slot_ff;
      tick_in      = tick_ff;
      prod_in      = prod_ff;
      inject       = 1'b0;
      div_start    = 1'b0;
      div_dividend = {1'b0, rate_ff};
      div_divisor  = WORD_W'(cfg.batch);
      ms_value     = cfg.milestones[slot_ff*MS_W +: MS_W];
      ms_hit       = (ms_value != '0) && (WORD_W'(ms_value) == it_ff);
      last_slot    = (slot_ff == SLOT_W'(MILESTONE_SLOTS - 1));
      scaled       = prod_ff >> FRACTION_BITS;

      case (state_ff)
         SCH_IDLE: begin
            if (tick_accept) begin
               it_in     = tick_iteration;
               before_in = rate_ff;
               tick_in   = 1'b1;
               slot_in   = '0;
               if (tick_iteration == '0) begin
                  state_in = SCH_INJECT;
               end else if (cfg.policy == POL_STEP && cfg.period != '0) begin
                  div_start    = 1'b1;
                  div_dividend = tick_iteration;
                  div_divisor  = cfg.period;
                  state_in     = SCH_MOD_WAIT;
               end else if (cfg.policy == POL_MULTI) begin
                  state_in = SCH_MS_CHECK;
               end else begin
                  state_in = SCH_INJECT;
               end
            end else if (rediv) begin
               tick_in  = 1'b0;
               state_in = SCH_DIV_START;
            end
         end
         SCH_MOD_WAIT: begin
            if (div_done) begin
               state_in = (div_remainder == '0) ? SCH_MUL : SCH_INJECT;
            end
         end
         SCH_MS_CHECK: begin
            if (ms_hit) begin
               state_in = SCH_MUL;
            end else if (last_slot) begin
               state_in = SCH_DIV_START;
            end else begin
               slot_in = SLOT_W'(slot_ff + 1'b1);
            end
         end
         SCH_MUL: begin
            prod_in  = rate_ff * cfg.gamma;
            state_in = SCH_SAT;
         end
         SCH_SAT: begin
            rate_in = (scaled > SPROD_W'(RATE_MAX)) ? RATE_MAX : scaled[RATE_W-1:0];
            if (cfg.policy == POL_MULTI && !last_slot) begin
               slot_in  = SLOT_W'(slot_ff + 1'b1);
               state_in = SCH_MS_CHECK;
            end else begin
               state_in = SCH_DIV_START;
            end
         end
         SCH_DIV_START: begin
            div_start = 1'b1;
            state_in  = SCH_DIV_WAIT;
         end
         SCH_DIV_WAIT: begin
            if (div_done) begin
               rb_in    = div_quotient[RATE_W-1:0];
               state_in = tick_ff ? SCH_INJECT : SCH_IDLE;
            end
         end
         SCH_INJECT: begin
            inject = 1'b1;
            if (dp_ready) begin
               tick_in  = 1'b0;
               state_in = SCH_IDLE;
            end
         end
         default: begin
            state_in = SCH_IDLE;
         end
      endcase

      // back-to-back register writes restart the refresh
      if (rediv && (state_ff == SCH_DIV_START || state_ff == SCH_DIV_WAIT)) begin
         state_in = SCH_DIV_START;
      end
      if (rate_load) begin
         rate_in = rate_load_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SCH_IDLE;
         rate_ff  <= RATE_RESET;
         rb_ff    <= RATE_RESET;
         tick_ff  <= 1'b0;
         slot_ff  <= '0;
      end else begin
         state_ff <= state_in;
         rate_ff  <= rate_in;
         rb_ff    <= rb_in;
         tick_ff  <= tick_in;
         slot_ff  <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      before_ff <= before_in;
      it_ff     <= it_in;
      prod_ff   <= prod_in;
   end

   assign status.busy       = (state_ff != SCH_IDLE);
   assign status.inject     = inject;
   assign status.rate       = rate_ff;
   assign status.rate_batch = rb_ff;
   assign status.changed    = (rate_ff != before_ff);

   a_div_owned: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> (state_ff == SCH_MOD_WAIT || state_ff == SCH_DIV_START ||
                    state_ff == SCH_DIV_WAIT))
      else $error("divider running outside a wait state");

   a_rate_hold: assert property (@(posedge clock) disable iff (reset)
      (!reset && state_ff != SCH_SAT && !rate_load) |=> (rate_ff == $past(rate_ff)))
      else $error("rate moved without a scale step or register write");

endmodule

// ===== src/smu_datapath.sv =====
// ----------------------------------------------------------------------------
// smu_datapath: five-stage element update pipeline
// Decay product, decay scaling, gradient correction, rate and momentum
// products, shift and saturate into the output register.
// ----------------------------------------------------------------------------
module smu_datapath #(
   parameter int FRACTION_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  smu_pkg::item_type                 in_item,
   output logic                              in_ready,
   input  logic [smu_pkg::RATE_W-1:0]        decay,
   input  logic [smu_pkg::RATE_W-1:0]        momentum,
   input  logic [smu_pkg::BATCH_W-1:0]       batch,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [smu_pkg::WORD_W-1:0] rsp_weight_out,
   output logic signed [smu_pkg::WORD_W-1:0] rsp_gradient_out,
   output logic [smu_pkg::RATE_W-1:0]        rsp_rate_out,
   output logic                              rsp_rate_changed
);
   import smu_pkg::*;

   logic adv1, adv2, adv3, adv4, adv5;
   logic s1_valid_ff, s1_valid_in, s2_valid_ff, s2_valid_in, s3_valid_ff, s3_valid_in;
   logic s4_valid_ff, s4_valid_in, s5_valid_ff, s5_valid_in;

   item_type                 s1_item_ff, s2_item_ff, s3_item_ff, s4_item_ff;
   logic signed [PROD_W-1:0] s1_pd_ff, pd_in;
   logic signed [TB_W-1:0]   s2_tb_ff, tb_in;
   logic signed [PROD_W-1:0] s4_pw_ff, s4_pg_ff, pw_in, pg_in;
   logic signed [PROD_W-1:0] tsh;
   logic signed [TERM_W-1:0] tcl;
   logic signed [DIFF_W-1:0] diff;
   logic signed [WORD_W-1:0] g1_in, wn_in, gn_in;
   logic signed [SAT_IN_W-1:0] wsum;

   // bubbles collapse: a stage moves when it is empty or the next one moves
   assign adv5     = !s5_valid_ff || !rsp_stall;
   assign adv4     = !s4_valid_ff || adv5;
   assign adv3     = !s3_valid_ff || adv4;
   assign adv2     = !s2_valid_ff || adv3;
   assign adv1     = !s1_valid_ff || adv2;
   assign in_ready = adv1;

   always_comb begin
      s1_valid_in = adv1 ? in_valid    : s1_valid_ff;
      s2_valid_in = adv2 ? s1_valid_ff : s2_valid_ff;
      s3_valid_in = adv3 ? s2_valid_ff : s3_valid_ff;
      s4_valid_in = adv4 ? s3_valid_ff : s4_valid_ff;
      s5_valid_in = adv5 ? s4_valid_ff : s5_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
         s5_valid_ff <= s5_valid_in;
      end
   end

   always_comb begin
      // stage 1: decay times weight
      pd_in = $signed({1'b0, decay}) * $signed(in_item.weight);

      // stage 2: floor shift, clamp, scale by batch
      tsh = s1_pd_ff >>> FRACTION_BITS;
      if (tsh > TERM_LIMIT) begin
         tcl = TERM_W'(TERM_LIMIT);
      end else if (tsh < -TERM_LIMIT) begin
         tcl = TERM_W'(-TERM_LIMIT);
      end else begin
         tcl = TERM_W'(tsh);
      end
      tb_in = tcl * $signed({1'b0, batch});

      // stage 3: corrected gradient
      diff  = DIFF_W'($signed(s2_item_ff.gradient)) - DIFF_W'(s2_tb_ff);
      g1_in = s2_item_ff.is_weights ? sat_word(SAT_IN_W'(diff))
                                    : $signed(s2_item_ff.gradient);

      // stage 4: rate/batch and momentum products
      pw_in = $signed({1'b0, s3_item_ff.rate_batch}) * $signed(s3_item_ff.gradient);
      pg_in = $signed({1'b0, momentum}) * $signed(s3_item_ff.gradient);

      // stage 5: shift, add, saturate
      wsum  = SAT_IN_W'(s4_pw_ff >>> FRACTION_BITS) + SAT_IN_W'($signed(s4_item_ff.weight));
      wn_in = s4_item_ff.tick ? '0 : sat_word(wsum);
      gn_in = s4_item_ff.tick ? '0 : sat_word(SAT_IN_W'(s4_pg_ff >>> FRACTION_BITS));
   end

   always_ff @(posedge clock) begin
      if (adv1 && in_valid) begin
         s1_item_ff <= in_item;
         s1_pd_ff   <= pd_in;
      end
      if (adv2 && s1_valid_ff) begin
         s2_item_ff <= s1_item_ff;
         s2_tb_ff   <= tb_in;
      end
      if (adv3 && s2_valid_ff) begin
         s3_item_ff          <= s2_item_ff;
         s3_item_ff.gradient <= g1_in;
      end
      if (adv4 && s3_valid_ff) begin
         s4_item_ff <= s3_item_ff;
         s4_pw_ff   <= pw_in;
         s4_pg_ff   <= pg_in;
      end
      if (adv5 && s4_valid_ff) begin
         rsp_weight_out   <= wn_in;
         rsp_gradient_out <= gn_in;
         rsp_rate_out     <= s4_item_ff.rate;
         rsp_rate_changed <= s4_item_ff.changed;
      end
   end

   assign rsp_valid = s5_valid_ff;

   a_tick_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_rate_changed) |-> (rsp_weight_out == '0 && rsp_gradient_out == '0))
      else $error("rate change flagged on an element beat");

endmodule

// ===== tb/sgd_momentum_update_step_lr_unit_tb.sv =====
// ----------------------------------------------------------------------------
// sgd_momentum_update_step_lr_unit_tb: self-checking bench for the SGD step
// Walks a short table of hand-picked beats and register settings, then runs
// random phases under random register settings. Each accepted request beat
// goes through a bit-true model of the optimiser step and the rate schedule.
// Response beats are checked in order against the model or, for known rows, fixed results.
// ----------------------------------------------------------------------------
module sgd_momentum_update_step_lr_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import smu_pkg::*;

   localparam int          FRAC          = 24;
   localparam int          SLOTS         = 4;
   localparam int          PHASES        = 13;
   localparam int          PHASE_BEATS   = 50;
   localparam int          HOLD_PHASE    = 2;
   localparam int          HOLD_CYCLES   = 150;
   localparam int          SETTLE        = 8;    // output pipe is five deep
   localparam int unsigned CYCLE_LIMIT   = 400000;

   localparam logic OP_ELEMENT = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   typedef struct packed {
      logic                     opcode;
      logic [WORD_W-1:0]        iteration;
      logic signed [WORD_W-1:0] weight;
      logic signed [WORD_W-1:0] gradient;
      logic                     is_weights;
   } req_beat_t;

   typedef struct packed {
      logic signed [WORD_W-1:0] weight;
      logic signed [WORD_W-1:0] gradient;
      logic [RATE_W-1:0]        rate;
      logic                     changed;
   } rsp_beat_t;

   typedef enum logic [1:0] {ROW_BEAT, ROW_KNOWN, ROW_CSR} row_kind_t;

   typedef struct {
      row_kind_t             kind;
      req_beat_t             beat;
      rsp_beat_t             result;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  value;
   } script_row_t;

   // ---------------------------------------------------------------------
   // DUT ports; every input is known from time zero
   // ---------------------------------------------------------------------
   logic                     clock           = 1'b0;
   logic                     reset           = 1'b1;
   logic                     req_valid       = 1'b0;
   logic                     req_stall;
   logic                     req_opcode      = OP_ELEMENT;
   logic [WORD_W-1:0]        req_iteration   = '0;
   logic signed [WORD_W-1:0] req_weight_in   = '0;
   logic signed [WORD_W-1:0] req_gradient_in = '0;
   logic                     req_is_weights  = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall       = 1'b0;
   logic signed [WORD_W-1:0] rsp_weight_out;
   logic signed [WORD_W-1:0] rsp_gradient_out;
   logic [RATE_W-1:0]        rsp_rate_out;
   logic                     rsp_rate_changed;
   logic                     csr_write       = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index       = CSR_INITIAL_RATE;
   logic [CSR_DATA_W-1:0]    csr_data        = '0;

   sgd_momentum_update_step_lr_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_iteration    (req_iteration),
      .req_weight_in    (req_weight_in),
      .req_gradient_in  (req_gradient_in),
      .req_is_weights   (req_is_weights),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_weight_out   (rsp_weight_out),
      .rsp_gradient_out (rsp_gradient_out),
      .rsp_rate_out     (rsp_rate_out),
      .rsp_rate_changed (rsp_rate_changed),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Model state: register copies and the running learning rate
   // ---------------------------------------------------------------------
   logic [RATE_W-1:0]   rate_now     = RATE_RESET;
   logic [RATE_W-1:0]   cfg_decay    = '0;
   logic [RATE_W-1:0]   cfg_momentum = '0;
   logic [RATE_W-1:0]   cfg_gamma    = GAMMA_RESET;
   logic [BATCH_W-1:0]  cfg_batch    = BATCH_ONE;
   logic [POLICY_W-1:0] cfg_policy   = POL_FIXED;
   logic [PERIOD_W-1:0] cfg_period   = 32'd1;
   logic [MS_ALL_W-1:0] cfg_marks    = '0;

   rsp_beat_t    pending_updates[$];   // model results not yet seen on rsp_
   script_row_t  script[$];
   int unsigned  fault_count  = 0;
   int unsigned  cycle_count  = 0;
   logic [1:0]   gap_mode     = 2'b00; // bit 0: sender gaps, bit 1: receiver stalls
   logic         hold_off_req = 1'b0;
   logic [WORD_W-1:0] iter_count;

   function automatic logic signed [WORD_W-1:0] clamp_word(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[WORD_W-1:0];
   endfunction

   function automatic logic [RATE_W-1:0] gamma_scale(input logic [RATE_W-1:0] r);
      logic [63:0] p;
      p = ({33'b0, r} * {33'b0, cfg_gamma}) >> FRAC;
      if (p > 64'h7FFF_FFFF) p = 64'h7FFF_FFFF;
      return p[RATE_W-1:0];
   endfunction

   // One optimiser step or schedule tick; ticks advance rate_now.
   function automatic rsp_beat_t compute_update(input req_beat_t b);
      rsp_beat_t          r;
      logic [BATCH_W-1:0] bsz;
      logic [RATE_W-1:0]  prior;
      logic [MS_W-1:0]    mark;
      longint             w, g, t, rb;
      bsz = (cfg_batch == '0) ? BATCH_ONE : cfg_batch;
      r = '0;
      if (b.opcode == OP_TICK) begin
         prior = rate_now;
         if (b.iteration != '0) begin
            case (cfg_policy)
               POL_STEP: begin
                  if (cfg_period != '0 && (b.iteration % cfg_period) == '0)
                     rate_now = gamma_scale(rate_now);
               end
               POL_MULTI: begin
                  for (int i = 0; i < SLOTS; i++) begin
                     mark = cfg_marks[MS_W*i +: MS_W];
                     if (mark != '0 && {16'b0, mark} == b.iteration)
                        rate_now = gamma_scale(rate_now);
                  end
               end
               default: ;
            endcase
         end
         r.rate    = rate_now;
         r.changed = (rate_now != prior);
      end else begin
         w = $signed(b.weight);
         g = $signed(b.gradient);
         if (b.is_weights) begin
            t = (longint'(cfg_decay) * w) >>> FRAC;
            if (t > (64'sd1 <<< 40)) t = 64'sd1 <<< 40;
            if (t < -(64'sd1 <<< 40)) t = -(64'sd1 <<< 40);
            g = clamp_word(g - t * longint'(bsz));
         end
         rb = longint'(rate_now / bsz);
         r.weight   = clamp_word(w + ((rb * g) >>> FRAC));
         r.gradient = clamp_word((longint'(cfg_momentum) * g) >>> FRAC);
         r.rate     = rate_now;
      end
      return r;
   endfunction

   function automatic req_beat_t mk_elem(input logic signed [WORD_W-1:0] w,
                                         input logic signed [WORD_W-1:0] g,
                                         input logic iw);
      req_beat_t b;
      b.opcode     = OP_ELEMENT;
      b.iteration  = '0;
      b.weight     = w;
      b.gradient   = g;
      b.is_weights = iw;
      return b;
   endfunction

   function automatic req_beat_t mk_tick(input logic [WORD_W-1:0] it);
      req_beat_t b;
      b = '0;
      b.opcode    = OP_TICK;
      b.iteration = it;
      return b;
   endfunction

   function automatic rsp_beat_t mk_result(input logic signed [WORD_W-1:0] w,
                                           input logic signed [WORD_W-1:0] g,
                                           input logic [RATE_W-1:0] r, input logic c);
      rsp_beat_t o;
      o.weight   = w;
      o.gradient = g;
      o.rate     = r;
      o.changed  = c;
      return o;
   endfunction

   task automatic add_beat_row(input req_beat_t b);
      script_row_t row;
      row.kind = ROW_BEAT;
      row.beat = b;
      script.push_back(row);
   endtask

   task automatic add_known_row(input req_beat_t b, input rsp_beat_t r);
      script_row_t row;
      row.kind   = ROW_KNOWN;
      row.beat   = b;
      row.result = r;
      script.push_back(row);
   endtask

   task automatic add_csr_row(input logic [CSR_INDEX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] val);
      script_row_t row;
      row.kind  = ROW_CSR;
      row.index = idx;
      row.value = val;
      script.push_back(row);
   endtask

   // Entered and left on a rising edge. A rate or batch write kicks off the
   // rate/batch refresh, so hold until req_stall drops again.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      case (idx)
         CSR_INITIAL_RATE: rate_now     = val[RATE_W-1:0];
         CSR_DECAY:        cfg_decay    = val[RATE_W-1:0];
         CSR_MOMENTUM:     cfg_momentum = val[RATE_W-1:0];
         CSR_GAMMA:        cfg_gamma    = val[RATE_W-1:0];
         CSR_BATCH_SIZE:   cfg_batch    = val[BATCH_W-1:0];
         CSR_POLICY:       cfg_policy   = val[POLICY_W-1:0];
         CSR_STEP_PERIOD:  cfg_period   = val[PERIOD_W-1:0];
         CSR_MILESTONES:   cfg_marks    = val[MS_ALL_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Offer one request beat, hold it until taken, then log the model or fixed result.
   task automatic send_beat(input req_beat_t b, input logic known, input rsp_beat_t fixed);
      rsp_beat_t model_out;
      if (gap_mode[0] && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= b.opcode;
      req_iteration   <= b.iteration;
      req_weight_in   <= b.weight;
      req_gradient_in <= b.gradient;
      req_is_weights  <= b.is_weights;
      do @(posedge clock); while (req_stall);
      model_out = compute_update(b);
      pending_updates.push_back(known ? fixed : model_out);
   endtask

   // Idle the sender and wait for every outstanding response beat.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_updates.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic signed [WORD_W-1:0] rand_word();
      logic signed [WORD_W-1:0] v;
      case ($urandom_range(0, 6))
         0: v = 32'sh7FFF_FFFF;
         1: v = 32'sh8000_0000;
         2: v = $urandom_range(0, 511) - 256;
         3, 4: v = $urandom_range(0, 1 << 27) - (1 << 26);  // about +/-4.0
         default: v = $urandom();
      endcase
      return v;
   endfunction

   // Mostly a counting sequence so step and milestone hits actually happen.
   function automatic logic [WORD_W-1:0] next_iteration();
      logic [WORD_W-1:0] it;
      case ($urandom_range(0, 9))
         6: it = $urandom_range(0, 70);
         7: it = $urandom();
         8: it = '0;
         9: it = {16'b0, cfg_marks[MS_W*$urandom_range(0, SLOTS-1) +: MS_W]};
         default: begin
            iter_count = iter_count + 1;
            it = iter_count;
         end
      endcase
      return it;
   endfunction

   // Random register setting for one phase; extremes turn up now and then.
   task automatic pick_config();
      logic [CSR_DATA_W-1:0] v;
      for (int i = 0; i < SLOTS; i++) begin
         case ($urandom_range(0, 5))
            0: v[MS_W*i +: MS_W] = '0;
            1: v[MS_W*i +: MS_W] = 16'hFFFF;
            default: v[MS_W*i +: MS_W] = $urandom_range(1, 40);
         endcase
      end
      if ($urandom_range(0, 5) == 0) v = {$urandom(), $urandom()};
      write_reg(CSR_MILESTONES, v);
      case ($urandom_range(0, 4))
         0: v = 64'd0;
         1: v = 64'hFFFF_FFFF;
         default: v = $urandom_range(1, 8);
      endcase
      write_reg(CSR_STEP_PERIOD, v);
      write_reg(CSR_POLICY, 64'($urandom_range(0, 3)));
      case ($urandom_range(0, 4))
         0: v = 64'd0;
         1: v = 64'd1;
         2: v = 64'd65535;
         3: v = $urandom_range(1, 64);
         default: v = 64'($urandom() & 32'hFFFF);
      endcase
      write_reg(CSR_BATCH_SIZE, v);
      case ($urandom_range(0, 4))
         0: v = 64'd0;
         1: v = 64'(RATE_MAX);
         4: v = 64'($urandom() & 32'h7FFF_FFFF);
         default: v = $urandom_range(1 << 23, 3 << 23);  // 0.5 .. 1.5
      endcase
      write_reg(CSR_GAMMA, v);
      case ($urandom_range(0, 4))
         0: v = 64'd0;
         1: v = 64'(RATE_MAX);
         2: v = 64'd15099494;                            // 0.9
         3: v = $urandom_range(0, 1 << 25);
         default: v = 64'($urandom() & 32'h7FFF_FFFF);
      endcase
      write_reg(CSR_MOMENTUM, v);
      case ($urandom_range(0, 4))
         0: v = 64'd0;
         1: v = 64'(RATE_MAX);
         4: v = 64'($urandom() & 32'h7FFF_FFFF);
         default: v = $urandom_range(0, 1 << 20);
      endcase
      write_reg(CSR_DECAY, v);
      case ($urandom_range(0, 4))
         0: v = 64'd0;
         1: v = 64'(RATE_MAX);
         4: v = 64'($urandom() & 32'h7FFF_FFFF);
         default: v = $urandom_range(1 << 16, 1 << 26);
      endcase
      write_reg(CSR_INITIAL_RATE, v);
   endtask

   // ---------------------------------------------------------------------
   // Receiver: random stall bursts, plus one long hold-off on request so the
   // element pipe backs up and pushes back on req_stall.
   // ---------------------------------------------------------------------
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_off_req = 1'b0;
         end else if (gap_mode[1] && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response check: every accepted beat against the oldest expected result
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      rsp_beat_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_updates.size() == 0) begin
            fault_count = fault_count + 1;
            if (fault_count <= 10)
               $display("cycle %0d: response beat with nothing outstanding", cycle_count);
         end else begin
            want = pending_updates.pop_front();
            if (rsp_weight_out !== want.weight || rsp_gradient_out !== want.gradient ||
                rsp_rate_out !== want.rate || rsp_rate_changed !== want.changed) begin
               fault_count = fault_count + 1;
               if (fault_count <= 10)
                  $display({"cycle %0d: weight exp %h got %h, gradient exp %h got %h, ",
                            "rate exp %h got %h, changed exp %b got %b"},
                           cycle_count, want.weight, rsp_weight_out, want.gradient,
                           rsp_gradient_out, want.rate, rsp_rate_out, want.changed,
                           rsp_rate_changed);
            end
         end
      end
   end

   // Watchdog: well over the slowest legal run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      req_beat_t b;
      int        tick_weight;

      // Reset values: rate 16777, no decay, no momentum, unit batch, fixed.
      add_known_row(mk_elem(32'sd0, 32'sd0, 1'b0), mk_result(32'sd0, 32'sd0, RATE_RESET, 1'b0));
      add_known_row(mk_elem(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1),
                    mk_result(32'sh7FFF_FFFF, 32'sd0, RATE_RESET, 1'b0));
      add_known_row(mk_elem(32'sh8000_0000, 32'sh8000_0000, 1'b0),
                    mk_result(32'sh8000_0000, 32'sd0, RATE_RESET, 1'b0));
      add_known_row(mk_tick(32'd0), mk_result(32'sd0, 32'sd0, RATE_RESET, 1'b0));
      add_known_row(mk_tick(32'hFFFF_FFFF), mk_result(32'sd0, 32'sd0, RATE_RESET, 1'b0));
      // Everything at full scale; zero batch acts as one, spare policy as fixed.
      add_csr_row(CSR_DECAY, 64'(RATE_MAX));
      add_csr_row(CSR_MOMENTUM, 64'(RATE_MAX));
      add_csr_row(CSR_BATCH_SIZE, 64'd0);
      add_csr_row(CSR_POLICY, 64'd3);
      add_csr_row(CSR_GAMMA, 64'(RATE_MAX));
      add_csr_row(CSR_INITIAL_RATE, 64'(RATE_MAX));
      add_beat_row(mk_elem(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1));
      add_beat_row(mk_elem(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1));
      add_beat_row(mk_elem(-32'sd1, 32'sd1, 1'b0));
      add_known_row(mk_tick(32'd5), mk_result(32'sd0, 32'sd0, RATE_MAX, 1'b0));
      // Periodic step: a zero period never fires.
      add_csr_row(CSR_POLICY, 64'(POL_STEP));
      add_csr_row(CSR_STEP_PERIOD, 64'd0);
      add_csr_row(CSR_BATCH_SIZE, 64'd65535);
      add_csr_row(CSR_INITIAL_RATE, 64'h100_0000);
      add_known_row(mk_tick(32'd7), mk_result(32'sd0, 32'sd0, 31'h100_0000, 1'b0));
      add_csr_row(CSR_STEP_PERIOD, 64'd3);
      add_csr_row(CSR_GAMMA, 64'h80_0000);
      add_known_row(mk_tick(32'd3), mk_result(32'sd0, 32'sd0, 31'h80_0000, 1'b1));
      add_known_row(mk_tick(32'd4), mk_result(32'sd0, 32'sd0, 31'h80_0000, 1'b0));
      // iteration zero is a multiple of anything but still changes nothing
      add_known_row(mk_tick(32'd0), mk_result(32'sd0, 32'sd0, 31'h80_0000, 1'b0));
      add_beat_row(mk_elem(32'sh0500_0000, -32'sh0300_0000, 1'b1));
      add_csr_row(CSR_STEP_PERIOD, 64'hFFFF_FFFF);
      add_known_row(mk_tick(32'hFFFF_FFFF), mk_result(32'sd0, 32'sd0, 31'h40_0000, 1'b1));
      // Milestones: slot 0 all ones, slots 1 and 2 repeated, slot 3 empty.
      add_csr_row(CSR_POLICY, 64'(POL_MULTI));
      add_csr_row(CSR_MILESTONES, 64'h0000_0005_0005_FFFF);
      add_known_row(mk_tick(32'd5), mk_result(32'sd0, 32'sd0, 31'h10_0000, 1'b1));
      add_known_row(mk_tick(32'hFFFF), mk_result(32'sd0, 32'sd0, 31'h8_0000, 1'b1));
      add_known_row(mk_tick(32'h1_0005), mk_result(32'sd0, 32'sd0, 31'h8_0000, 1'b0));
      add_known_row(mk_tick(32'h1_0000), mk_result(32'sd0, 32'sd0, 31'h8_0000, 1'b0));
      // Zero gamma wipes the rate; a second hit leaves it at zero, unflagged.
      add_csr_row(CSR_GAMMA, 64'd0);
      add_known_row(mk_tick(32'd5), mk_result(32'sd0, 32'sd0, 31'd0, 1'b1));
      add_known_row(mk_tick(32'd5), mk_result(32'sd0, 32'sd0, 31'd0, 1'b0));
      // Large gamma saturates the rate.
      add_csr_row(CSR_GAMMA, 64'(RATE_MAX));
      add_csr_row(CSR_INITIAL_RATE, 64'h4000_0000);
      add_known_row(mk_tick(32'hFFFF), mk_result(32'sd0, 32'sd0, RATE_MAX, 1'b1));
      add_beat_row(mk_elem(32'sh1234_5678, -32'sh0ABC_DEF0, 1'b1));
      add_beat_row(mk_elem(-32'sh0765_4321, 32'sh0FED_CBA9, 1'b0));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed table, no random gaps; results drain before each run of register writes.
      foreach (script[i]) begin
         if (script[i].kind == ROW_CSR) begin
            if (i > 0 && script[i-1].kind != ROW_CSR) drain_results();
            write_reg(script[i].index, script[i].value);
         end else begin
            send_beat(script[i].beat, script[i].kind == ROW_KNOWN, script[i].result);
         end
      end

      // Random phases, one register setting each.
      for (int ph = 0; ph < PHASES; ph++) begin
         drain_results();
         pick_config();
         iter_count  = '0;
         tick_weight = $urandom_range(0, 3);
         if (ph == PHASES - 1) begin
            gap_mode = 2'b00;                // quiet tail
         end else if (ph == HOLD_PHASE) begin
            gap_mode     = 2'b00;            // sender flat out into a stalled sink
            tick_weight  = 0;
            hold_off_req = 1'b1;
         end else begin
            gap_mode = $urandom_range(0, 3);
         end
         repeat (PHASE_BEATS) begin
            b.iteration  = $urandom();
            b.weight     = rand_word();
            b.gradient   = rand_word();
            b.is_weights = $urandom_range(0, 1);
            if ($urandom_range(0, 7) < tick_weight) begin
               b.opcode    = OP_TICK;
               b.iteration = next_iteration();
            end else begin
               b.opcode = OP_ELEMENT;
            end
            send_beat(b, 1'b0, '0);
         end
      end

      drain_results();
      if (fault_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== files.f =====
src/smu_pkg.sv
src/smu_divider.sv
src/smu_sched.sv
src/smu_datapath.sv
src/sgd_momentum_update_step_lr_unit.sv
tb/sgd_momentum_update_step_lr_unit_tb.sv
